// File: src/cmq_pkg.sv
`timescale 1ns / 1ps

package cmq_pkg;

	// Sizing of the block.
	localparam int MAX_CHANNELS = 16;
	localparam int QUEUE_DEPTH  = 64;
	localparam int HANDLE_BITS  = 16;

	// Fixed field widths of the request and response transactions.
	localparam int KIND_W    = 3;
	localparam int ID_W      = 32;
	localparam int HANDLE_W  = 16;
	localparam int POS_W     = 4;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 7;

	// Derived widths.
	localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int TOT_W   = $clog2(MAX_CHANNELS + 1);
	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LEN_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int STORE_DEPTH = MAX_CHANNELS * QUEUE_DEPTH;
	localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int SLOT_W  = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int CMP_W   = (TOT_W > POS_W) ? TOT_W : POS_W;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_CREATE = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ENQ    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DEQ    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_COUNT  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_POS    = 3'd4;

	// Response status codes.
	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_CHANNEL   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd4;
	localparam logic [STATUS_W-1:0] ST_QUEUE_FULL   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_BAD_POSITION = 3'd6;

	// One entry of the per-channel pointer memory.
	typedef struct packed {
		logic [PTR_W-1:0] head;
		logic [PTR_W-1:0] tail;
		logic [LEN_W-1:0] len;
	} ptr_word_t;

endpackage

// File: src/cmq_if.sv
`timescale 1ns / 1ps

// Request channel.
interface cmq_req_if;
	logic                        valid;
	logic                        ready;
	logic [cmq_pkg::KIND_W-1:0]   kind;
	logic [cmq_pkg::ID_W-1:0]     channel_id;
	logic [cmq_pkg::HANDLE_W-1:0] message_handle;
	logic [cmq_pkg::POS_W-1:0]    position;

	modport source (output valid, kind, channel_id, message_handle, position, input ready);
	modport sink   (input valid, kind, channel_id, message_handle, position, output ready);
endinterface

// Response channel.
interface cmq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [cmq_pkg::STATUS_W-1:0] status;
	logic [cmq_pkg::HANDLE_W-1:0] out_handle;
	logic [cmq_pkg::COUNT_W-1:0]  out_count;
	logic [cmq_pkg::ID_W-1:0]     out_channel_id;

	modport source (output valid, status, out_handle, out_count, out_channel_id, input ready);
	modport sink   (input valid, status, out_handle, out_count, out_channel_id, output ready);
endinterface

// File: src/channel_table_multi_queue.sv
`timescale 1ns / 1ps

// Channel  Direction  Payload
// req      in         kind, channel_id, message_handle, position
// rsp      out        status, out_handle, out_count, out_channel_id
//
// Each request passes through an accept step, an id lookup that also reads
// the pointer memory, an execute step that updates pointers and the message
// store, and a result step that loads the response register.
// Reset clears the channel count, the sequencer and the response valid; the
// memories need no clearing because no entry's contents are used before it is written.
// A stalled response holds in its register while the next request is taken.

module channel_table_multi_queue (
	input  logic            clk,
	input  logic            arst_n,
	cmq_req_if.sink         req,
	cmq_rsp_if.source       rsp
);

	typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EXEC, S_RESULT} state_t;

	state_t state_q;

	// Captured request.
	logic [cmq_pkg::KIND_W-1:0]   kind_q;
	logic [cmq_pkg::ID_W-1:0]     id_q;
	logic [cmq_pkg::HANDLE_W-1:0] handle_q;
	logic [cmq_pkg::POS_W-1:0]    pos_q;

	// Channel table: ids live in registers so that all of them can be compared
	// against the requested id at once. Entries at or above the count are stale.
	logic [cmq_pkg::ID_W-1:0]  ids_q [cmq_pkg::MAX_CHANNELS];
	logic [cmq_pkg::TOT_W-1:0] total_q;

	// Lookup results.
	logic                     hit_q;
	logic [cmq_pkg::CH_W-1:0] idx_q;
	logic                     look_hit;
	logic [cmq_pkg::CH_W-1:0] look_idx;

	// Pointer memory, one word per channel.
	cmq_pkg::ptr_word_t ptr_mem [cmq_pkg::MAX_CHANNELS];
	cmq_pkg::ptr_word_t ptr_rd_q;
	logic               ptr_we;
	logic [cmq_pkg::CH_W-1:0] ptr_wa;
	cmq_pkg::ptr_word_t ptr_wd;

	// Message store, QUEUE_DEPTH slots per channel.
	logic [cmq_pkg::SLOT_W-1:0] store_mem [cmq_pkg::STORE_DEPTH];
	logic [cmq_pkg::SLOT_W-1:0] store_rd_q;
	logic                       store_we;
	logic                       store_re;
	logic [cmq_pkg::ADDR_W-1:0] store_addr;

	// Execute-cycle decisions, held for the result cycle.
	logic [cmq_pkg::STATUS_W-1:0] ex_status;
	logic [cmq_pkg::COUNT_W-1:0]  ex_count;
	logic [cmq_pkg::ID_W-1:0]     ex_id;
	logic                         ex_create;
	logic [cmq_pkg::STATUS_W-1:0] st_q;
	logic [cmq_pkg::COUNT_W-1:0]  cnt_q;
	logic [cmq_pkg::ID_W-1:0]     oid_q;
	logic                         deq_q;

	// Response register.
	logic                         rsp_valid_q;
	logic [cmq_pkg::STATUS_W-1:0] rsp_status_q;
	logic [cmq_pkg::HANDLE_W-1:0] rsp_handle_q;
	logic [cmq_pkg::COUNT_W-1:0]  rsp_count_q;
	logic [cmq_pkg::ID_W-1:0]     rsp_id_q;

	logic [cmq_pkg::PTR_W-1:0] head_next;
	logic [cmq_pkg::PTR_W-1:0] tail_next;
	logic [cmq_pkg::CH_W-1:0]  pos_idx;
	logic                      pos_ok;
	logic                      rsp_load;

	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.out_handle     = rsp_handle_q;
	assign rsp.out_count      = rsp_count_q;
	assign rsp.out_channel_id = rsp_id_q;

	// The result cycle loads the response register once it is free or being
	// emptied at this edge.
	assign rsp_load = (state_q == S_RESULT) && (!rsp_valid_q || rsp.ready);

	// Ids are unique among live entries, so at most one entry matches and the
	// index is a plain OR of the matching positions.
	always_comb begin
		look_hit = 1'b0;
		look_idx = '0;
		for (int i = 0; i < cmq_pkg::MAX_CHANNELS; i++) begin
			if ((cmq_pkg::TOT_W'(i) < total_q) && (ids_q[i] == id_q)) begin
				look_hit = 1'b1;
				look_idx = look_idx | cmq_pkg::CH_W'(i);
			end
		end
	end

	// Circular pointer advance.
	assign head_next = (ptr_rd_q.head == cmq_pkg::PTR_W'(cmq_pkg::QUEUE_DEPTH - 1)) ?
		'0 : ptr_rd_q.head + 1'b1;
	assign tail_next = (ptr_rd_q.tail == cmq_pkg::PTR_W'(cmq_pkg::QUEUE_DEPTH - 1)) ?
		'0 : ptr_rd_q.tail + 1'b1;

	// A position is good only below the number of channels created so far.
	assign pos_ok  = cmq_pkg::CMP_W'(pos_q) < cmq_pkg::CMP_W'(total_q);
	assign pos_idx = cmq_pkg::CH_W'(pos_q);

	// Execute cycle: decide the status and drive the memory write ports.
	always_comb begin
		ex_status  = cmq_pkg::ST_OK;
		ex_count   = '0;
		ex_id      = '0;
		ex_create  = 1'b0;
		ptr_we     = 1'b0;
		ptr_wa     = idx_q;
		ptr_wd     = ptr_rd_q;
		store_we   = 1'b0;
		store_re   = 1'b0;
		store_addr = cmq_pkg::ADDR_W'(idx_q) * cmq_pkg::ADDR_W'(cmq_pkg::QUEUE_DEPTH)
			+ cmq_pkg::ADDR_W'(ptr_rd_q.tail);
		case (kind_q)
			cmq_pkg::KIND_CREATE: begin
				if (hit_q) begin
					ex_status = cmq_pkg::ST_DUPLICATE;
				end else if (total_q == cmq_pkg::TOT_W'(cmq_pkg::MAX_CHANNELS)) begin
					ex_status = cmq_pkg::ST_TABLE_FULL;
				end else begin
					ex_create = 1'b1;
					ptr_we    = 1'b1;
					ptr_wa    = total_q[cmq_pkg::CH_W-1:0];
					ptr_wd    = '0;
				end
			end
			cmq_pkg::KIND_ENQ: begin
				if (!hit_q) begin
					ex_status = cmq_pkg::ST_NO_CHANNEL;
				end else if (ptr_rd_q.len >= cmq_pkg::LEN_W'(cmq_pkg::QUEUE_DEPTH)) begin
					ex_status = cmq_pkg::ST_QUEUE_FULL;
					ex_count  = cmq_pkg::COUNT_W'(ptr_rd_q.len);
				end else begin
					store_we    = 1'b1;
					ptr_we      = 1'b1;
					ptr_wd.tail = tail_next;
					ptr_wd.len  = ptr_rd_q.len + 1'b1;
					ex_count    = cmq_pkg::COUNT_W'(ptr_rd_q.len + 1'b1);
				end
			end
			cmq_pkg::KIND_DEQ: begin
				store_addr = cmq_pkg::ADDR_W'(idx_q) * cmq_pkg::ADDR_W'(cmq_pkg::QUEUE_DEPTH)
					+ cmq_pkg::ADDR_W'(ptr_rd_q.head);
				if (!hit_q) begin
					ex_status = cmq_pkg::ST_NO_CHANNEL;
				end else if (ptr_rd_q.len == '0) begin
					ex_status = cmq_pkg::ST_EMPTY;
				end else begin
					store_re    = 1'b1;
					ptr_we      = 1'b1;
					ptr_wd.head = head_next;
					ptr_wd.len  = ptr_rd_q.len - 1'b1;
					ex_count    = cmq_pkg::COUNT_W'(ptr_rd_q.len - 1'b1);
				end
			end
			cmq_pkg::KIND_COUNT: begin
				if (!hit_q) begin
					ex_status = cmq_pkg::ST_NO_CHANNEL;
				end else begin
					ex_count = cmq_pkg::COUNT_W'(ptr_rd_q.len);
				end
			end
			cmq_pkg::KIND_POS: begin
				if (!pos_ok) begin
					ex_status = cmq_pkg::ST_BAD_POSITION;
				end else begin
					ex_id = ids_q[pos_idx];
				end
			end
			default: begin
				// Kinds without meaning answer ok with all fields zero.
			end
		endcase
		if (state_q != S_EXEC) begin
			ptr_we    = 1'b0;
			store_we  = 1'b0;
			store_re  = 1'b0;
			ex_create = 1'b0;
		end
	end

	// Pointer memory: read in the lookup cycle, written in the execute cycle.
	always_ff @(posedge clk) begin
		if (ptr_we) begin
			ptr_mem[ptr_wa] <= ptr_wd;
		end
		if (state_q == S_LOOK) begin
			ptr_rd_q <= ptr_mem[look_idx];
		end
	end

	// Message store: at most one access per request, in the execute cycle.
	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[store_addr] <= handle_q[cmq_pkg::SLOT_W-1:0];
		end
		if (store_re) begin
			store_rd_q <= store_mem[store_addr];
		end
	end

	// Channel id registers, appended on a successful create.
	always_ff @(posedge clk) begin
		if (ex_create) begin
			ids_q[total_q[cmq_pkg::CH_W-1:0]] <= id_q;
		end
	end

	// Sequencer and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						kind_q   <= req.kind;
						id_q     <= req.channel_id;
						handle_q <= req.message_handle;
						pos_q    <= req.position;
						state_q  <= S_LOOK;
					end
				end
				S_LOOK: begin
					hit_q   <= look_hit;
					idx_q   <= look_idx;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					st_q    <= ex_status;
					cnt_q   <= ex_count;
					oid_q   <= ex_id;
					deq_q   <= store_re;
					if (ex_create) begin
						total_q <= total_q + 1'b1;
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					// Wait here only while an earlier response is still unclaimed.
					if (rsp_load) begin
						rsp_status_q <= st_q;
						rsp_count_q  <= cnt_q;
						rsp_id_q     <= oid_q;
						rsp_handle_q <= deq_q ? cmq_pkg::HANDLE_W'(store_rd_q) : '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/cmq_checker.sv
`timescale 1ns / 1ps

module cmq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [cmq_pkg::STATUS_W-1:0] status,
	input logic [cmq_pkg::HANDLE_W-1:0] out_handle,
	input logic [cmq_pkg::COUNT_W-1:0]  out_count,
	input logic [cmq_pkg::ID_W-1:0]     out_channel_id
);

	// A stalled response keeps its status.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
		else $error("response dropped or changed while stalled");

	// One request at a time: no accept right after an accept.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// A failed request carries no handle and no id.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != cmq_pkg::ST_OK) |-> (out_handle == '0) && (out_channel_id == '0))
		else $error("failed request returned data");

	// Queue lengths never pass the queue depth, and the status is a known code.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (int'(out_count) <= cmq_pkg::QUEUE_DEPTH) &&
		(status <= cmq_pkg::ST_BAD_POSITION))
		else $error("count or status out of range");

endmodule

bind channel_table_multi_queue cmq_checker u_cmq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.status         (rsp.status),
	.out_handle     (rsp.out_handle),
	.out_count      (rsp.out_count),
	.out_channel_id (rsp.out_channel_id)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cmq_pkg::*;

	// The run ends with a failure if it is still going after this many cycles.
	localparam int unsigned CYCLE_LIMIT = 200000;
	// Request transactions to issue in all, the directed part included.
	localparam int unsigned ITEM_TARGET = 900;

	// One response transaction, field by field.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] out_handle;
		logic [COUNT_W-1:0]  out_count;
		logic [ID_W-1:0]     out_channel_id;
	} response_t;

	// Tracks the channel table and every channel's message queue, and holds the
	// responses that the block still owes, oldest first.
	class channel_queue_tracker;
		logic [ID_W-1:0]     channel_ids [MAX_CHANNELS];
		int unsigned         channel_total;
		int unsigned         heads [MAX_CHANNELS];
		int unsigned         tails [MAX_CHANNELS];
		int unsigned         lengths [MAX_CHANNELS];
		logic [HANDLE_W-1:0] store [STORE_DEPTH];
		logic [HANDLE_W-1:0] slot_mask;
		response_t           expected_responses [$];
		int unsigned         failures;

		function new();
			channel_total = 0;
			failures = 0;
			slot_mask = HANDLE_W'((64'd1 << SLOT_W) - 64'd1);
		endfunction

		function int find_channel(logic [ID_W-1:0] id);
			for (int i = 0; i < channel_total; i++) begin
				if (channel_ids[CH_W'(i)] == id) begin
					return i;
				end
			end
			return -1;
		endfunction

		function int unsigned pending();
			return expected_responses.size();
		endfunction

		function void note_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
				logic [HANDLE_W-1:0] handle, logic [POS_W-1:0] pos);
			response_t r;
			int ch;
			logic [CH_W-1:0] ci;
			logic [CH_W-1:0] ni;
			r = '0;
			case (kind)
				KIND_CREATE: begin
					if (find_channel(id) >= 0) begin
						r.status = ST_DUPLICATE;
					end else if (channel_total >= MAX_CHANNELS) begin
						r.status = ST_TABLE_FULL;
					end else begin
						ni = CH_W'(channel_total);
						channel_ids[ni] = id;
						heads[ni] = 0;
						tails[ni] = 0;
						lengths[ni] = 0;
						channel_total++;
					end
				end
				KIND_ENQ, KIND_DEQ, KIND_COUNT: begin
					ch = find_channel(id);
					if (ch < 0) begin
						r.status = ST_NO_CHANNEL;
					end else begin
						ci = CH_W'(ch);
						if (kind == KIND_ENQ) begin
							if (lengths[ci] >= QUEUE_DEPTH) begin
								r.status = ST_QUEUE_FULL;
							end else begin
								store[ADDR_W'(ch * QUEUE_DEPTH + tails[ci])] =
									handle & slot_mask;
								tails[ci] = (tails[ci] + 1) % QUEUE_DEPTH;
								lengths[ci]++;
							end
						end else if (kind == KIND_DEQ) begin
							if (lengths[ci] == 0) begin
								r.status = ST_EMPTY;
							end else begin
								r.out_handle = store[ADDR_W'(ch * QUEUE_DEPTH + heads[ci])];
								heads[ci] = (heads[ci] + 1) % QUEUE_DEPTH;
								lengths[ci]--;
							end
						end
						r.out_count = COUNT_W'(lengths[ci]);
					end
				end
				KIND_POS: begin
					if (int'(unsigned'(pos)) >= channel_total) begin
						r.status = ST_BAD_POSITION;
					end else begin
						r.out_channel_id = channel_ids[pos];
					end
				end
				default: begin
				end
			endcase
			expected_responses.push_back(r);
		endfunction

		function void check_response(response_t actual);
			response_t want;
			if (expected_responses.size() == 0) begin
				$error("response with no request outstanding: status %0d", actual.status);
				failures++;
				return;
			end
			want = expected_responses.pop_front();
			if (actual.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, actual.status);
				failures++;
			end
			if (actual.out_handle !== want.out_handle) begin
				$error("out_handle: expected %0h, actual %0h", want.out_handle,
					actual.out_handle);
				failures++;
			end
			if (actual.out_count !== want.out_count) begin
				$error("out_count: expected %0d, actual %0d", want.out_count,
					actual.out_count);
				failures++;
			end
			if (actual.out_channel_id !== want.out_channel_id) begin
				$error("out_channel_id: expected %0h, actual %0h", want.out_channel_id,
					actual.out_channel_id);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	cmq_req_if req_ch ();
	cmq_rsp_if rsp_ch ();

	channel_table_multi_queue u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	channel_queue_tracker tracker;

	// Upper bounds of the per-transaction idle draw on each side. They are
	// redrawn every so often, so that some stretches of the run have no idle
	// cycles at all and others have gaps on both sides.
	int unsigned req_gap_max;
	int unsigned rsp_gap_max;
	int unsigned items_sent;
	int unsigned cycle_count;

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Drives one request transaction and holds it until the block accepts it.
	// The idle gap is drawn first; valid drops only when a gap follows, so it
	// is never lowered and raised again at the same edge.
	task automatic issue_request(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
			logic [HANDLE_W-1:0] handle, logic [POS_W-1:0] pos);
		int unsigned gap;
		gap = $urandom_range(0, req_gap_max);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.kind           <= kind;
		req_ch.channel_id     <= id;
		req_ch.message_handle <= handle;
		req_ch.position       <= pos;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		// The transaction was taken at this edge, so the tracker steps now.
		tracker.note_request(kind, id, handle, pos);
		items_sent++;
		if (items_sent % 64 == 0) begin
			req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
			rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
		end
	endtask

	// Any channel that exists, drawn uniformly.
	function automatic logic [ID_W-1:0] pick_existing_id();
		return tracker.channel_ids[CH_W'($urandom_range(0, tracker.channel_total - 1))];
	endfunction

	// Mostly the id of a channel that exists, sometimes an arbitrary one that
	// will usually miss the table.
	function automatic logic [ID_W-1:0] pick_channel_id();
		if (tracker.channel_total > 0 && $urandom_range(0, 9) < 8) begin
			return pick_existing_id();
		end
		return $urandom;
	endfunction

	// Response side: stalls at random, then takes one response transaction
	// and hands it to the tracker for comparison.
	initial begin
		int unsigned stall;
		response_t got;
		@(posedge clk);
		while (!arst_n) begin
			@(posedge clk);
		end
		forever begin
			stall = $urandom_range(0, rsp_gap_max);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!rsp_ch.valid);
			got.status         = rsp_ch.status;
			got.out_handle     = rsp_ch.out_handle;
			got.out_count      = rsp_ch.out_count;
			got.out_channel_id = rsp_ch.out_channel_id;
			tracker.check_response(got);
		end
	end

	initial begin
		logic [ID_W-1:0] id;
		int unsigned pick;
		tracker = new();
		req_gap_max = 3;
		rsp_gap_max = 3;
		items_sent = 0;
		cycle_count = 0;
		arst_n <= 1'b0;
		req_ch.valid          <= 1'b0;
		req_ch.kind           <= KIND_CREATE;
		req_ch.channel_id     <= '0;
		req_ch.message_handle <= '0;
		req_ch.position       <= '0;
		rsp_ch.ready          <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. With the table still empty, a lookup by id and a
		// lookup by position must both miss.
		issue_request(KIND_COUNT, '0, '0, '0);
		issue_request(KIND_POS, '0, '0, '0);
		// The extreme ids, then a duplicate create that must leave the table alone.
		issue_request(KIND_CREATE, '0, '0, '0);
		issue_request(KIND_CREATE, '1, '0, '0);
		issue_request(KIND_CREATE, '0, '1, '1);
		// Extreme handles go in and must come back out in order, after which
		// the queue is empty again.
		issue_request(KIND_ENQ, '0, '1, '0);
		issue_request(KIND_ENQ, '0, '0, '1);
		issue_request(KIND_ENQ, '1, 16'h5a5a, '0);
		issue_request(KIND_COUNT, '0, '0, '0);
		issue_request(KIND_DEQ, '0, '0, '0);
		issue_request(KIND_DEQ, '0, '0, '0);
		issue_request(KIND_DEQ, '0, '0, '0);
		// Requests that address a channel that was never created.
		issue_request(KIND_DEQ, 32'h0001_2345, '0, '0);
		issue_request(KIND_ENQ, 32'h0001_2345, 16'ha5a5, '0);
		issue_request(KIND_COUNT, 32'h8000_0000, '0, '0);
		// Position lookups inside and past the end of the table.
		issue_request(KIND_POS, '0, '0, 4'd1);
		issue_request(KIND_POS, '0, '0, 4'd2);
		issue_request(KIND_POS, '1, '1, '1);
		// Kinds without meaning must change nothing and answer all zeros.
		for (int k = 1; k <= 3; k++) begin
			issue_request(KIND_W'(KIND_POS + k), '1, '1, '1);
		end
		issue_request(KIND_DEQ, '1, '0, '0);
		issue_request(KIND_COUNT, '1, '0, '0);

		// Random part. Most requests address existing channels so the queues
		// see real traffic; occasional bursts drive one queue past full and
		// then past empty. Creates are frequent enough that the table fills
		// partway through and the table-full answer shows up.
		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				if (tracker.channel_total > 0 && $urandom_range(0, 9) < 3) begin
					id = pick_channel_id();
				end else begin
					id = $urandom;
				end
				issue_request(KIND_CREATE, id, HANDLE_W'($urandom), POS_W'($urandom));
			end else if (pick < 40) begin
				issue_request(KIND_ENQ, pick_channel_id(), HANDLE_W'($urandom),
					POS_W'($urandom));
			end else if (pick < 65) begin
				issue_request(KIND_DEQ, pick_channel_id(), HANDLE_W'($urandom),
					POS_W'($urandom));
			end else if (pick < 78) begin
				issue_request(KIND_COUNT, pick_channel_id(), HANDLE_W'($urandom),
					POS_W'($urandom));
			end else if (pick < 93) begin
				issue_request(KIND_POS, $urandom, HANDLE_W'($urandom),
					POS_W'($urandom_range(0, 15)));
			end else if (pick < 96) begin
				issue_request(KIND_W'(KIND_POS + $urandom_range(1, 3)), $urandom,
					HANDLE_W'($urandom), POS_W'($urandom));
			end else if (pick < 98 || tracker.channel_total == 0) begin
				issue_request(KIND_COUNT, $urandom, HANDLE_W'($urandom), POS_W'($urandom));
			end else if (pick == 98) begin
				// Overfill one queue; the last enqueues must bounce as full.
				id = pick_existing_id();
				repeat (QUEUE_DEPTH + $urandom_range(1, 3)) begin
					issue_request(KIND_ENQ, id, HANDLE_W'($urandom), POS_W'($urandom));
				end
			end else begin
				// Drain one queue completely and then some.
				id = pick_existing_id();
				repeat (QUEUE_DEPTH + $urandom_range(1, 3)) begin
					issue_request(KIND_DEQ, id, HANDLE_W'($urandom), POS_W'($urandom));
				end
			end
		end
		req_ch.valid <= 1'b0;

		// Let every owed response arrive, then keep the clock running so that the
		// block can show any response it should not send.
		while (tracker.pending() != 0) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);

		if (tracker.failures == 0 && tracker.pending() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
